/* hdl/dqs_pkg.sv */
// Shared types and codes for the bounded deque with sorted insert.
// Used by dqs_ctrl, dqs_dp and the top level; depends on nothing.
`default_nettype none

package dqs_pkg;

  // Action codes of an input item
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_SORTED_INS = 3'd4;
  localparam logic [2:0] ACT_PEEK       = 3'd5;

  // Status codes of a result item
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Value reported when there is nothing to report
  localparam logic signed [31:0] NONE_VALUE = -32'sd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY,
    ST_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the input item
    logic cmp;      // compute the insert position
    logic apply;    // update the cells and count
    logic result;   // load the output register
  } dqs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a new item
  } dqs_stat_t;

endpackage

`default_nettype wire

/* hdl/bounded_deque_with_sorted_insert.sv */
// Bounded deque with sorted insert: top level joining controller and datapath.
// Depends on dqs_pkg, dqs_ctrl and dqs_dp.
//
// Usage:
//   Input channel (in_valid/in_ready, in_action, in_value) takes one item:
//   push front, push back, pop front, pop back, sorted insert or peek.
//   Result channel (out_valid/out_ready) returns exactly one item per input:
//   removed value, front, back, entry count, empty flag and status.
//   An accepted item passes through the controller sequence capture, position
//   search, cell shift and result load; its result is registered in the result
//   load step once the output register is free. Items are handled one at a time.
//   The next item is accepted while the previous result waits in the output
//   register. When the receiver stalls, the block holds in the result load
//   step and stops taking items until the output register frees.
//   Reset (synchronous, rst_n low) empties the list and drops any pending
//   result; cell contents are not cleared and are never read until written.
`default_nettype none

module bounded_deque_with_sorted_insert
  import dqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_action,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_removed_value,
  output logic signed [31:0]      out_front_value,
  output logic signed [31:0]      out_back_value,
  output logic [4:0]              out_entry_count,
  output logic                    out_is_empty,
  output logic [1:0]              out_status
);

  dqs_cmd_t  cmd;
  dqs_stat_t stat;

  // Sequence one item at a time
  dqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the list and build results
  dqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_action         (in_action),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_removed_value (out_removed_value),
    .out_front_value   (out_front_value),
    .out_back_value    (out_back_value),
    .out_entry_count   (out_entry_count),
    .out_is_empty      (out_is_empty),
    .out_status        (out_status)
  );

endmodule

`default_nettype wire

/* hdl/dqs_ctrl.sv */
// Controller state machine for the bounded deque with sorted insert.
// Depends on dqs_pkg; drives dqs_dp through dqs_cmd_t.
`default_nettype none

module dqs_ctrl
  import dqs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dqs_stat_t stat,
  output dqs_cmd_t       cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CMP;
      end
      ST_CMP:   state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_CMP:    cmd.cmp    = 1'b1;
      ST_APPLY:  cmd.apply  = 1'b1;
      ST_RESULT: cmd.result = stat.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/dqs_dp.sv */
// Datapath for the bounded deque with sorted insert: shifting cell row,
// entry count, insert position search and output register. Depends on dqs_pkg.
`default_nettype none

module dqs_dp
  import dqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dqs_cmd_t           cmd,
  output dqs_stat_t               stat,
  input  wire logic [2:0]         in_action,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_removed_value,
  output logic signed [31:0]      out_front_value,
  output logic signed [31:0]      out_back_value,
  output logic [4:0]              out_entry_count,
  output logic                    out_is_empty,
  output logic [1:0]              out_status
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] cell_r [DEPTH];
  logic [CW-1:0]      count_r;
  logic [2:0]         act_r;
  logic signed [31:0] val_r;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic signed [31:0] removed_r;
  logic [1:0]         status_r;
  logic               out_valid_r;
  logic               full, empty;
  logic [IW-1:0]      last_idx;
  logic               is_ins;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign last_idx = IW'(count_r - CW'(1));
  assign is_ins   = (act_r == ACT_PUSH_FRONT) || (act_r == ACT_PUSH_BACK) ||
                    (act_r == ACT_SORTED_INS);

  // Hold the input item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      val_r <= in_value;
    end
  end

  // Find the insert position: lowest later cell not below the value
  always_comb begin
    pos_nxt = count_r;
    for (int i = DEPTH - 1; i >= 1; i--) begin
      if ((CW'(i) < count_r) && !(cell_r[i] < val_r)) pos_nxt = CW'(i);
    end
    if (empty || (val_r < cell_r[0])) pos_nxt = '0;
    if (act_r == ACT_PUSH_FRONT) pos_nxt = '0;
    if (act_r == ACT_PUSH_BACK)  pos_nxt = count_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp) pos_r <= pos_nxt;
  end

  // Shift the cells: open a slot on insert, close the front on pop front
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (is_ins && !full) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (CW'(i) == pos_r) begin
            cell_r[i] <= val_r;
          end else if ((i > 0) && (CW'(i) > pos_r)) begin
            cell_r[i] <= cell_r[(i > 0) ? i - 1 : 0];
          end
        end
      end else if ((act_r == ACT_POP_FRONT) && !empty) begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          cell_r[i] <= cell_r[i + 1];
        end
      end
    end
  end

  // Advance the count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      if (is_ins && !full) begin
        count_r <= count_r + CW'(1);
      end else if (((act_r == ACT_POP_FRONT) || (act_r == ACT_POP_BACK)) && !empty) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // Record removed value and status
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      removed_r <= NONE_VALUE;
      status_r  <= STAT_DONE;
      case (act_r)
        ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_SORTED_INS: begin
          if (full) status_r <= STAT_FULL;
        end
        ACT_POP_FRONT: begin
          if (empty) status_r <= STAT_EMPTY;
          else removed_r <= cell_r[0];
        end
        ACT_POP_BACK: begin
          if (empty) status_r <= STAT_EMPTY;
          else removed_r <= cell_r[last_idx];
        end
        default: begin
          status_r <= STAT_DONE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      out_removed_value <= removed_r;
      out_front_value   <= empty ? NONE_VALUE : cell_r[0];
      out_back_value    <= empty ? NONE_VALUE : cell_r[last_idx];
      out_entry_count   <= 5'(count_r);
      out_is_empty      <= empty;
      out_status        <= status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

/* verif/deque_checker.sv */
`timescale 1ns / 100ps
// Checker for the bounded deque with sorted insert: predicts each result item
// from the input items it sees accepted and compares it field by field.
// Depends on dqs_pkg for the action and status codes.

module deque_checker
  import dqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_removed_value,
  input  logic signed [31:0] out_front_value,
  input  logic signed [31:0] out_back_value,
  input  logic [4:0]         out_entry_count,
  input  logic               out_is_empty,
  input  logic [1:0]         out_status,
  output int                 report_errors,
  output int                 report_backlog
);

  typedef struct {
    logic signed [31:0] removed;
    logic signed [31:0] front;
    logic signed [31:0] back;
    logic [4:0]         count;
    logic               empty;
    logic [1:0]         status;
  } deque_report_t;

  // Shadow copy of the list, front at index 0
  logic signed [31:0] shadow [DEPTH];
  int                 shadow_n = 0;
  deque_report_t      deque_reports_q[$];
  int                 mismatches = 0;

  // Slot for a sorted insert: below the front goes first, otherwise
  // before the first later entry that is not below the value
  function automatic int sorted_slot(logic signed [31:0] val);
    int i;
    if (shadow_n == 0 || val < shadow[0]) return 0;
    for (i = 1; i < shadow_n; i++)
      if (!(shadow[i] < val)) return i;
    return shadow_n;
  endfunction

  // Apply one action to the shadow list and build the report it yields
  function automatic deque_report_t apply_deque_op(logic [2:0] act,
                                                   logic signed [31:0] val);
    deque_report_t r;
    int pos;
    int i;
    r.removed = NONE_VALUE;
    r.status  = STAT_DONE;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_SORTED_INS: begin
        if (shadow_n >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          if (act == ACT_PUSH_FRONT) pos = 0;
          else if (act == ACT_PUSH_BACK) pos = shadow_n;
          else pos = sorted_slot(val);
          for (i = shadow_n; i > pos; i--) shadow[i] = shadow[i-1];
          shadow[pos] = val;
          shadow_n++;
        end
      end
      ACT_POP_FRONT: begin
        if (shadow_n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.removed = shadow[0];
          shadow_n--;
          for (i = 0; i < shadow_n; i++) shadow[i] = shadow[i+1];
        end
      end
      ACT_POP_BACK: begin
        if (shadow_n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          shadow_n--;
          r.removed = shadow[shadow_n];
        end
      end
      default: ;  // peek and the spare codes leave the list alone
    endcase
    r.front = (shadow_n != 0) ? shadow[0] : NONE_VALUE;
    r.back  = (shadow_n != 0) ? shadow[shadow_n-1] : NONE_VALUE;
    r.count = shadow_n[4:0];
    r.empty = (shadow_n == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // Compare the outgoing item first: it always belongs to an older input
  always @(posedge clk) begin
    deque_report_t want;
    if (!rst_n) begin
      shadow_n = 0;
      deque_reports_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (deque_reports_q.size() == 0) begin
          $error("result item arrived with no expectation pending");
          mismatches++;
        end else begin
          want = deque_reports_q.pop_front();
          check_field("out_removed_value", want.removed, out_removed_value);
          check_field("out_front_value", want.front, out_front_value);
          check_field("out_back_value", want.back, out_back_value);
          check_field("out_entry_count", {27'd0, want.count}, {27'd0, out_entry_count});
          check_field("out_is_empty", {31'd0, want.empty}, {31'd0, out_is_empty});
          check_field("out_status", {30'd0, want.status}, {30'd0, out_status});
        end
      end
      if (in_valid && in_ready)
        deque_reports_q.push_back(apply_deque_op(in_action, in_value));
    end
    report_errors  <= mismatches;
    report_backlog <= deque_reports_q.size();
  end

endmodule

/* verif/tb_bounded_deque_with_sorted_insert.sv */
`timescale 1ns / 100ps
// Testbench top for the bounded deque with sorted insert: clock, reset,
// directed and random items under several idling patterns, and the verdict.
// Depends on dqs_pkg, the block itself and deque_checker.

module tb_bounded_deque_with_sorted_insert;
  import dqs_pkg::*;

  localparam int DEPTH        = 16;
  localparam int HALF_PERIOD  = 4;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1524;
  localparam int BATCH_ITEMS  = 40;
  localparam int SETTLE       = 20;

  // Codes outside the defined set; the block treats them as peek
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_action = ACT_PEEK;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_removed_value;
  logic signed [31:0] out_front_value;
  logic signed [31:0] out_back_value;
  logic [4:0]         out_entry_count;
  logic               out_is_empty;
  logic [1:0]         out_status;

  int   report_errors;
  int   report_backlog;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  always #(HALF_PERIOD) clk = ~clk;

  bounded_deque_with_sorted_insert #(.DEPTH(DEPTH)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_removed_value(out_removed_value),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_status       (out_status)
  );

  deque_checker #(.DEPTH(DEPTH)) u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_removed_value(out_removed_value),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_status       (out_status),
    .report_errors    (report_errors),
    .report_backlog   (report_backlog)
  );

  // Drive out_ready: one long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic [2:0] act, input logic signed [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly growing or mostly shrinking by grow_pct, with a little noise
  function automatic logic [2:0] pick_action(int grow_pct);
    if ($urandom_range(99) < 4) begin
      case ($urandom_range(2))
        0:       return ACT_PEEK;
        1:       return ACT_SPARE_A;
        default: return ACT_SPARE_B;
      endcase
    end
    if ($urandom_range(99) < grow_pct) begin
      case ($urandom_range(3))
        0:       return ACT_PUSH_FRONT;
        1:       return ACT_PUSH_BACK;
        default: return ACT_SORTED_INS;
      endcase
    end
    return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
  endfunction

  // Extremes, a narrow band that makes ties, or any 32-bit value
  function automatic logic signed [31:0] pick_value();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) begin
      case ($urandom_range(3))
        0:       return 32'sh7fffffff;
        1:       return 32'sh80000000;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if (roll <= 4) return int'($urandom_range(16)) - 8;
    return $urandom;
  endfunction

  initial begin
    int grow_pct;
    int phase;
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pops, peek and spare codes, extremes, sorted placement
    send_item(ACT_POP_FRONT, 32'sd5);
    send_item(ACT_POP_BACK, -32'sd5);
    send_item(ACT_PEEK, 32'sd1);
    send_item(ACT_SPARE_A, 32'sd2);
    send_item(ACT_SPARE_B, 32'sd3);
    send_item(ACT_PUSH_FRONT, 32'sh7fffffff);
    send_item(ACT_PUSH_BACK, 32'sh80000000);
    send_item(ACT_SORTED_INS, 32'sd0);
    send_item(ACT_SORTED_INS, -32'sd1);
    send_item(ACT_SORTED_INS, 32'sd5);
    send_item(ACT_SORTED_INS, 32'sd0);
    // fill to the top, then every insert kind is refused
    repeat (DEPTH - 6) send_item(ACT_SORTED_INS, pick_value());
    send_item(ACT_PUSH_FRONT, 32'sd9);
    send_item(ACT_PUSH_BACK, 32'sd9);
    send_item(ACT_SORTED_INS, 32'sd9);
    send_item(ACT_POP_FRONT, 32'sd0);
    send_item(ACT_POP_BACK, 32'sd0);

    // Random: no idling with one long receiver hold-off, then each idling mix
    grow_pct = 50;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct <= 0;  hold_req <= 1'b1; end
        1:       begin send_idle_pct = 77; stall_pct <= 0;  end
        2:       begin send_idle_pct = 0;  stall_pct <= 77; end
        default: begin send_idle_pct = 13; stall_pct <= 13; end
      endcase
      for (n = 0; n < RANDOM_ITEMS / 4; n++) begin
        if (n % BATCH_ITEMS == 0) begin
          case ($urandom_range(2))
            0:       grow_pct = 85;
            1:       grow_pct = 50;
            default: grow_pct = 15;
          endcase
        end
        send_item(pick_action(grow_pct), pick_value());
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then allow for the block's latency
    @(posedge clk);
    while (report_backlog != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (report_errors == 0 && report_backlog == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
